>>> design/tlbpt_pkg.sv
`default_nettype none

package tlbpt_pkg;

  localparam int DEF_TLB_ENTRIES = 16;
  localparam int DEF_PAGE_COUNT  = 256;
  localparam int DEF_FRAME_COUNT = 256;
  localparam int DEF_FRAME_BYTES = 256;

  localparam int VA_W   = 16;
  localparam int BYTE_W = 8;
  localparam int CNT_W  = 32;
  localparam int BYTE_CODES = 256;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  typedef struct packed {
    logic [VA_W-1:0] virtual_address;
  } request_t;

  typedef struct packed {
    logic [VA_W-1:0]   physical_address;
    logic [BYTE_W-1:0] frame_number;
    logic              tlb_hit;
    logic              table_hit;
    logic              page_fault;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
  } result_t;

  // Broadcast from the sequencer to every TLB cell.
  typedef struct packed {
    logic update;
    logic hit;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LOOKUP
  } state_t;

endpackage

`default_nettype wire

>>> design/tlbpt_stream_if.sv
`default_nettype none

interface tlbpt_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tlbpt_cell.sv
`default_nettype none

// One TLB entry. Position in the chain is the recency rank (0 = most recent).
module tlbpt_cell #(
  parameter int PAGE_W  = 8,
  parameter int FRAME_W = 8
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire tlbpt_pkg::cell_cmd_t cmd,
  input  wire logic [PAGE_W-1:0]  probe_page,
  input  wire logic               prev_valid,
  input  wire logic [PAGE_W-1:0]  prev_page,
  input  wire logic [FRAME_W-1:0] prev_frame,
  input  wire logic               seen_in,
  input  wire logic [FRAME_W-1:0] found_in,
  output logic                    valid,
  output logic [PAGE_W-1:0]       page,
  output logic [FRAME_W-1:0]      frame,
  output logic                    seen_out,
  output logic [FRAME_W-1:0]      found_out
);

  logic match;
  logic shift;

  assign match     = valid && (page == probe_page);
  assign seen_out  = seen_in || match;
  assign found_out = (match && !seen_in) ? frame : found_in;

  // Shift every cell up to and including the hit; on a miss shift all.
  assign shift = cmd.update && !(cmd.hit && seen_in);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      page  <= prev_page;
      frame <= prev_frame;
    end
  end

endmodule

`default_nettype wire

>>> design/tlbpt_table.sv
`default_nettype none

// Page table: valid bits in flops, frames in a memory, plus frame allocator.
module tlbpt_table #(
  parameter int PAGE_COUNT  = 256,
  parameter int FRAME_COUNT = 256,
  localparam int PAGE_W  = $clog2(PAGE_COUNT),
  localparam int FRAME_W = $clog2(FRAME_COUNT)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic [PAGE_W-1:0]  rd_page,
  input  wire logic               alloc,
  input  wire logic [PAGE_W-1:0]  alloc_page,
  output logic                    rd_valid,
  output logic [FRAME_W-1:0]      rd_frame,
  output logic [FRAME_W-1:0]      free_frame
);

  localparam logic [FRAME_W-1:0] LAST_FRAME = FRAME_W'(FRAME_COUNT - 1);

  logic [PAGE_COUNT-1:0] page_valid;
  logic [FRAME_W-1:0]    frame_mem [PAGE_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      page_valid <= '0;
      free_frame <= '0;
    end else if (alloc) begin
      page_valid[alloc_page] <= 1'b1;
      free_frame <= (free_frame == LAST_FRAME) ? '0 : free_frame + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      frame_mem[alloc_page] <= free_frame;
    end
    if (rd_en) begin
      rd_frame <= frame_mem[rd_page];
      rd_valid <= page_valid[rd_page];
    end
  end

endmodule

`default_nettype wire

>>> design/tlb_page_table_translator_top.sv
// The accepted address is registered with its page-table read, then the result is loaded
//   into the output register. A new address is taken only in ST_IDLE while the output
//   register is free or draining; ST_LOOKUP runs the TLB cell chain compare and commits.
// Reset (rst, synchronous): clears TLB valid bits, page-table valid flops, the frame
//   allocator and both counters; there is no clearing pass.
`default_nettype none

module tlb_page_table_translator_top #(
  parameter int TLB_ENTRIES = tlbpt_pkg::DEF_TLB_ENTRIES,
  parameter int PAGE_COUNT  = tlbpt_pkg::DEF_PAGE_COUNT,
  parameter int FRAME_COUNT = tlbpt_pkg::DEF_FRAME_COUNT,
  parameter int FRAME_BYTES = tlbpt_pkg::DEF_FRAME_BYTES
) (
  input  wire logic      clk,
  input  wire logic      rst,
  tlbpt_stream_if.sink   addr,
  tlbpt_stream_if.source xlat
);

  localparam int PAGE_W  = $clog2(PAGE_COUNT);
  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int OFF_W   = $clog2(FRAME_BYTES);
  localparam int VA_W    = tlbpt_pkg::VA_W;
  localparam int BYTE_W  = tlbpt_pkg::BYTE_W;
  localparam int CNT_W   = tlbpt_pkg::CNT_W;

  // Page and offset folding: constant tables built at elaboration.
  logic [PAGE_W-1:0] page_map [tlbpt_pkg::BYTE_CODES];
  logic [OFF_W-1:0]  off_map  [tlbpt_pkg::BYTE_CODES];

  for (genvar g = 0; g < tlbpt_pkg::BYTE_CODES; g++) begin : g_map
    assign page_map[g] = PAGE_W'(g % PAGE_COUNT);
    assign off_map[g]  = OFF_W'(g % FRAME_BYTES);
  end

  tlbpt_pkg::state_t  state, state_next;
  tlbpt_pkg::request_t req;
  tlbpt_pkg::result_t  rslt, rslt_next;
  tlbpt_pkg::cell_cmd_t cmd;

  logic              accept;
  logic              lookup;
  logic              out_valid;
  logic [PAGE_W-1:0] page_q;
  logic [OFF_W-1:0]  off_q;
  logic [CNT_W-1:0]  hit_counter, hit_counter_next;
  logic [CNT_W-1:0]  fault_counter, fault_counter_next;

  assign req    = addr.data;
  assign accept = addr.valid && addr.ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      tlbpt_pkg::ST_IDLE:   if (accept) state_next = tlbpt_pkg::ST_LOOKUP;
      tlbpt_pkg::ST_LOOKUP: state_next = tlbpt_pkg::ST_IDLE;
      default:              state_next = tlbpt_pkg::ST_IDLE;
    endcase
  end

  // Take a new address only when idle and the output register is free or draining.
  always_comb begin
    addr.ready = 1'b0;
    lookup     = 1'b0;
    unique case (state)
      tlbpt_pkg::ST_IDLE:   addr.ready = !out_valid || xlat.ready;
      tlbpt_pkg::ST_LOOKUP: lookup = 1'b1;
      default:              addr.ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tlbpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the folded page and offset for the lookup cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      page_q <= page_map[req.virtual_address[VA_W-1:BYTE_W]];
      off_q  <= off_map[req.virtual_address[BYTE_W-1:0]];
    end
  end

  // --------------------------------------------------------------- page table
  logic               tbl_valid;
  logic [FRAME_W-1:0] tbl_frame;
  logic [FRAME_W-1:0] free_frame;
  logic               fault;

  tlbpt_table #(
    .PAGE_COUNT  (PAGE_COUNT),
    .FRAME_COUNT (FRAME_COUNT)
  ) u_table (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (accept),
    .rd_page    (page_map[req.virtual_address[VA_W-1:BYTE_W]]),
    .alloc      (fault),
    .alloc_page (page_q),
    .rd_valid   (tbl_valid),
    .rd_frame   (tbl_frame),
    .free_frame (free_frame)
  );

  // ------------------------------------------------------------ TLB cell chain
  // Cell i holds the entry of recency rank i. A hit at rank p moves that entry
  // to the head and pushes ranks 0..p-1 down one; a miss pushes every cell and
  // drops the tail, which is the free slot while filling and the LRU victim after.
  logic               cell_valid [TLB_ENTRIES];
  logic [PAGE_W-1:0]  cell_page  [TLB_ENTRIES];
  logic [FRAME_W-1:0] cell_frame [TLB_ENTRIES];
  logic               seen       [TLB_ENTRIES+1];
  logic [FRAME_W-1:0] found      [TLB_ENTRIES+1];
  logic [FRAME_W-1:0] frame_sel;
  logic               tlb_hit;

  assign seen[0]  = 1'b0;
  assign found[0] = '0;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    logic               prev_valid;
    logic [PAGE_W-1:0]  prev_page;
    logic [FRAME_W-1:0] prev_frame;

    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
      assign prev_page  = page_q;
      assign prev_frame = frame_sel;
    end else begin : g_link
      assign prev_valid = cell_valid[i-1];
      assign prev_page  = cell_page[i-1];
      assign prev_frame = cell_frame[i-1];
    end

    tlbpt_cell #(
      .PAGE_W  (PAGE_W),
      .FRAME_W (FRAME_W)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cmd),
      .probe_page (page_q),
      .prev_valid (prev_valid),
      .prev_page  (prev_page),
      .prev_frame (prev_frame),
      .seen_in    (seen[i]),
      .found_in   (found[i]),
      .valid      (cell_valid[i]),
      .page       (cell_page[i]),
      .frame      (cell_frame[i]),
      .seen_out   (seen[i+1]),
      .found_out  (found[i+1])
    );
  end

  // --------------------------------------------------------- resolve and commit
  assign tlb_hit = seen[TLB_ENTRIES];
  assign fault   = lookup && !tlb_hit && !tbl_valid;
  assign cmd     = '{update: lookup, hit: tlb_hit};

  always_comb begin
    if (tlb_hit) begin
      frame_sel = found[TLB_ENTRIES];
    end else if (tbl_valid) begin
      frame_sel = tbl_frame;
    end else begin
      frame_sel = free_frame;
    end
  end

  // Saturate both running counts.
  always_comb begin
    hit_counter_next   = hit_counter;
    fault_counter_next = fault_counter;
    if (lookup && tlb_hit && hit_counter != tlbpt_pkg::CNT_MAX) begin
      hit_counter_next = hit_counter + 1'b1;
    end
    if (fault && fault_counter != tlbpt_pkg::CNT_MAX) begin
      fault_counter_next = fault_counter + 1'b1;
    end
  end

  always_comb begin
    rslt_next.physical_address = VA_W'(VA_W'(frame_sel) * VA_W'(FRAME_BYTES))
                                 + VA_W'(off_q);
    rslt_next.frame_number     = BYTE_W'(frame_sel);
    rslt_next.tlb_hit          = tlb_hit;
    rslt_next.table_hit        = !tlb_hit && tbl_valid;
    rslt_next.page_fault       = !tlb_hit && !tbl_valid;
    rslt_next.hit_total        = hit_counter_next;
    rslt_next.fault_total      = fault_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_counter   <= '0;
      fault_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      hit_counter   <= hit_counter_next;
      fault_counter <= fault_counter_next;
      if (lookup) begin
        out_valid <= 1'b1;
      end else if (xlat.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result beat at the end of the lookup cycle; hold it until taken.
  always_ff @(posedge clk) begin
    if (lookup) begin
      rslt <= rslt_next;
    end
  end

  assign xlat.valid = out_valid;
  assign xlat.data  = rslt;

endmodule

`default_nettype wire

>>> tb/tlb_page_table_translator_top_test.sv
module tlb_page_table_translator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TLB_N  = tlbpt_pkg::DEF_TLB_ENTRIES;
  localparam int PAGES  = tlbpt_pkg::DEF_PAGE_COUNT;
  localparam int FRAMES = tlbpt_pkg::DEF_FRAME_COUNT;
  localparam int FBYTES = tlbpt_pkg::DEF_FRAME_BYTES;

  localparam int VA_W   = tlbpt_pkg::VA_W;
  localparam int BYTE_W = tlbpt_pkg::BYTE_W;
  localparam int CNT_W  = tlbpt_pkg::CNT_W;
  localparam logic [CNT_W-1:0] CNT_MAX = tlbpt_pkg::CNT_MAX;

  // Random beats per idling phase; three phases plus the directed opener
  // come to roughly 1900 addresses.
  localparam int PHASE_ADDRS = 625;
  // Long receiver hold-off that lets the block fill up and stall its input.
  localparam int HOLD_CYCLES = 120;
  // Cycles without any beat on either channel before the run is abandoned.
  // The worst legal quiet stretch is the hold-off plus the pipeline's own delay.
  localparam int STALL_LIMIT = 3000;
  // Extra cycles after draining that give the pipe time to show stray
  // beats.
  localparam int SETTLE_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  tlbpt_stream_if #(.payload_t(tlbpt_pkg::request_t)) addr_ch ();
  tlbpt_stream_if #(.payload_t(tlbpt_pkg::result_t))  xlat_ch ();

  tlb_page_table_translator_top uut (
    .clk  (clk),
    .rst  (rst),
    .addr (addr_ch),
    .xlat (xlat_ch)
  );

  // ---------------------------------------------------------------------
  // Translation predictor: its own copy of the TLB, the page table, the
  // frame allocator and the running counters.
  // ---------------------------------------------------------------------
  logic [BYTE_W-1:0] tlb_tag  [TLB_N];
  logic [BYTE_W-1:0] tlb_frm  [TLB_N];
  bit                tlb_live [TLB_N];
  int                tlb_rank [TLB_N];   // 0 = most recently used
  int                tlb_used = 0;
  bit                pt_live  [PAGES];
  logic [BYTE_W-1:0] pt_frame [PAGES];
  int                frame_cursor = 0;
  logic [CNT_W-1:0]  hit_count = '0;
  logic [CNT_W-1:0]  fault_count = '0;
  int                table_hit_count = 0;
  bit                frames_wrapped = 1'b0;

  // Make an entry most recent; live entries ranked below its old rank age by one.
  function automatic void promote_entry(int idx, int old_rank);
    for (int i = 0; i < TLB_N; i++) begin
      if (i != idx && tlb_live[i] && tlb_rank[i] < old_rank) tlb_rank[i]++;
    end
    tlb_rank[idx] = 0;
  endfunction

  // Fill free slots in index order; once full, replace the oldest entry
  // (on equal ranks the highest index is chosen).
  function automatic void install_mapping(int page, int frame);
    int slot;
    int old_rank;
    if (tlb_used < TLB_N) begin
      slot = tlb_used;
      tlb_used++;
      old_rank = TLB_N;
    end else begin
      slot = 0;
      old_rank = 0;
      for (int i = 0; i < TLB_N; i++) begin
        if (tlb_rank[i] >= old_rank) begin
          old_rank = tlb_rank[i];
          slot = i;
        end
      end
    end
    tlb_tag[slot]  = BYTE_W'(page);
    tlb_frm[slot]  = BYTE_W'(frame);
    tlb_live[slot] = 1'b1;
    promote_entry(slot, old_rank);
  endfunction

  function automatic tlbpt_pkg::result_t translate(logic [VA_W-1:0] va);
    int page;
    int offset;
    int frame;
    bit found;
    tlbpt_pkg::result_t r;
    page   = int'(va[VA_W-1:BYTE_W]) % PAGES;
    offset = int'(va[BYTE_W-1:0]) % FBYTES;
    frame  = 0;
    found  = 1'b0;
    r      = '0;
    for (int i = 0; i < TLB_N; i++) begin
      if (!found && tlb_live[i] && tlb_tag[i] == BYTE_W'(page)) begin
        frame = tlb_frm[i];
        promote_entry(i, tlb_rank[i]);
        found = 1'b1;
      end
    end
    if (found) begin
      r.tlb_hit = 1'b1;
      if (hit_count != CNT_MAX) hit_count++;
    end else if (pt_live[page]) begin
      r.table_hit = 1'b1;
      table_hit_count++;
      frame = pt_frame[page];
      install_mapping(page, frame);
    end else begin
      // Page fault: take the next frame; the allocator wraps without eviction.
      r.page_fault = 1'b1;
      if (fault_count != CNT_MAX) fault_count++;
      frame = frame_cursor % FRAMES;
      if (frame == FRAMES - 1) frames_wrapped = 1'b1;
      frame_cursor = (frame + 1) % FRAMES;
      pt_live[page]  = 1'b1;
      pt_frame[page] = BYTE_W'(frame);
      install_mapping(page, frame);
    end
    r.physical_address = VA_W'(frame * FBYTES + offset);
    r.frame_number     = BYTE_W'(frame);
    r.hit_total        = hit_count;
    r.fault_total      = fault_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Queues, knobs and bookkeeping shared by the processes below.
  // ---------------------------------------------------------------------
  tlbpt_pkg::request_t address_backlog[$];   // addresses the driver has yet to offer
  tlbpt_pkg::result_t  predicted_xlat[$];    // translations still owed by the block
  int       items_queued = 0;
  int       addrs_accepted = 0;
  int       results_seen = 0;
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       holds_asked = 0;
  int       holds_done = 0;
  int       hold_left = 0;
  int       idle_run = 0;
  int       hot_base = 0;
  logic     addr_taken = 1'b0;

  task automatic report_mismatch(string what, logic [CNT_W-1:0] got, logic [CNT_W-1:0] want);
    errors++;
    $display("[%0t] xlat beat %0d: %s got 0x%0h want 0x%0h", $time, results_seen, what, got,
             want);
  endtask

  task automatic check_xlat(tlbpt_pkg::result_t got);
    tlbpt_pkg::result_t want;
    results_seen++;
    if (predicted_xlat.size() == 0) begin
      report_mismatch("unexpected beat, physical_address", CNT_W'(got.physical_address), '0);
    end else begin
      want = predicted_xlat.pop_front();
      if (got.physical_address != want.physical_address)
        report_mismatch("physical_address", CNT_W'(got.physical_address),
                        CNT_W'(want.physical_address));
      if (got.frame_number != want.frame_number)
        report_mismatch("frame_number", CNT_W'(got.frame_number), CNT_W'(want.frame_number));
      if (got.tlb_hit != want.tlb_hit)
        report_mismatch("tlb_hit", CNT_W'(got.tlb_hit), CNT_W'(want.tlb_hit));
      if (got.table_hit != want.table_hit)
        report_mismatch("table_hit", CNT_W'(got.table_hit), CNT_W'(want.table_hit));
      if (got.page_fault != want.page_fault)
        report_mismatch("page_fault", CNT_W'(got.page_fault), CNT_W'(want.page_fault));
      if (got.hit_total != want.hit_total)
        report_mismatch("hit_total", got.hit_total, want.hit_total);
      if (got.fault_total != want.fault_total)
        report_mismatch("fault_total", got.fault_total, want.fault_total);
    end
  endtask

  task automatic queue_address(logic [VA_W-1:0] va);
    tlbpt_pkg::request_t req;
    req.virtual_address = va;
    address_backlog.push_back(req);
    items_queued++;
  endtask

  // Mostly a sliding working set of pages, so the TLB sees hits, refills
  // from the page table and LRU evictions; the rest is spread over all pages.
  function automatic logic [VA_W-1:0] random_address();
    int roll;
    int page;
    int offset;
    if ($urandom_range(0, 49) == 0) hot_base = (hot_base + $urandom_range(1, 40)) % PAGES;
    roll = $urandom_range(0, 99);
    if (roll < 15)      page = $urandom_range(0, 255);
    else if (roll < 85) page = (hot_base + $urandom_range(0, 11)) % 256;
    else                page = (hot_base + $urandom_range(0, 40)) % 256;
    roll = $urandom_range(0, 19);
    if (roll == 0)      offset = 0;
    else if (roll == 1) offset = 255;
    else                offset = $urandom_range(0, 255);
    return {BYTE_W'(page), BYTE_W'(offset)};
  endfunction

  // Hold the caller until every queued address went in and every
  // translation came back; returns just after a rising edge.
  task automatic wait_until_drained();
    do @(negedge clk);
    while (addrs_accepted != items_queued || predicted_xlat.size() != 0);
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // Driver: offer address beats on the falling edge; hold a beat until it
  // is taken, then advance to the next one or idle at random.
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      addr_ch.valid <= 1'b0;
      addr_ch.data  <= '0;
    end else if (!addr_ch.valid || addr_taken) begin
      if (address_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        addr_ch.valid <= 1'b1;
        addr_ch.data  <= address_backlog.pop_front();
      end else begin
        addr_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off counted here on request.
  always @(negedge clk) begin
    if (rst) begin
      xlat_ch.ready <= 1'b0;
      hold_left     <= 0;
    end else if (holds_done != holds_asked) begin
      xlat_ch.ready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      holds_done    <= holds_done + 1;
    end else if (hold_left != 0) begin
      xlat_ch.ready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else begin
      xlat_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: on the rising edge predict every accepted address, check every
  // accepted translation, and watch for a hung block.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      addr_taken <= 1'b0;
      idle_run   <= 0;
    end else begin
      addr_taken <= addr_ch.valid && addr_ch.ready;
      if (addr_ch.valid && addr_ch.ready) begin
        predicted_xlat.push_back(translate(addr_ch.data.virtual_address));
        addrs_accepted++;
      end
      if (xlat_ch.valid && xlat_ch.ready) check_xlat(xlat_ch.data);
      if ((addr_ch.valid && addr_ch.ready) || (xlat_ch.valid && xlat_ch.ready)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("timeout: %0d cycles without a beat, %0d translations outstanding",
                 idle_run, predicted_xlat.size());
        $display("[tlb_page_table_translator_top] ERROR");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus sequence.
  // ---------------------------------------------------------------------
  initial begin
    int mark;
    addr_ch.valid = 1'b0;
    addr_ch.data  = '0;
    xlat_ch.ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Directed opener, no idling on either side.
    queue_address(16'h0000);          // first fault takes frame 0
    queue_address(16'h00FF);          // TLB hit, top offset
    queue_address(16'hFFFF);          // top page, all ones
    queue_address(16'hFF00);          // TLB hit, zero offset
    for (int i = 1; i <= 14; i++)     // fill the remaining free TLB slots
      queue_address({BYTE_W'(i), BYTE_W'($urandom_range(0, 255))});
    queue_address(16'h0012);          // refresh page 0; page FF is now the oldest
    queue_address(16'h0F34);          // fault into a full TLB, evicts page FF
    queue_address(16'hFF80);          // page-table hit on the evicted page
    queue_address(16'h01C3);          // page-table hit, evicts the next oldest
    queue_address(16'h55AA);          // alternating bit patterns
    queue_address(16'hAA55);
    wait_until_drained();

    // Sender idles lightly, receiver stalls heavily.
    send_idle_pct = 11;
    recv_idle_pct = 47;
    repeat (PHASE_ADDRS) queue_address(random_address());
    wait_until_drained();

    // Roles swapped.
    send_idle_pct = 47;
    recv_idle_pct = 11;
    repeat (PHASE_ADDRS) queue_address(random_address());
    wait_until_drained();

    // Full rate, with one long receiver hold-off while addresses keep coming.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (PHASE_ADDRS) queue_address(random_address());
    mark = addrs_accepted + 40;
    do @(negedge clk);
    while (addrs_accepted < mark);
    @(posedge clk);
    holds_asked++;
    wait_until_drained();

    // Let the pipe settle to expose any stray beat.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (predicted_xlat.size() != 0)
      report_mismatch("translations never delivered", CNT_W'(predicted_xlat.size()), '0);

    $display("covered %0d addresses: %0d TLB hits, %0d page-table hits, %0d page faults",
             addrs_accepted, hit_count, table_hit_count, fault_count);
    $display("%0d translations checked, %0d mismatches, frame allocator wrapped: %0d",
             results_seen, errors, frames_wrapped);
    if (errors == 0) begin
      $display("[tlb_page_table_translator_top] OK");
    end else begin
      $display("[tlb_page_table_translator_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
design/tlbpt_pkg.sv
design/tlbpt_stream_if.sv
design/tlbpt_cell.sv
design/tlbpt_table.sv
design/tlb_page_table_translator_top.sv
tb/tlb_page_table_translator_top_test.sv
